/* sv/itew_pkg.sv */
`timescale 1ns / 1ps
// Shared constants, token codes and the data record passed along the conversion chain
// of the integer to English word token unit. Depends on nothing.
package itew_pkg;

    localparam int BinW          = 32;
    localparam int DigitW        = 4;
    localparam int BcdDigits     = 10;
    localparam int BcdW          = BcdDigits * DigitW;
    localparam int NumCells      = BinW;
    localparam int Groups        = 4;
    localparam int GroupW        = 3 * DigitW;
    localparam int DigsW         = Groups * GroupW;
    localparam int SlotsPerGroup = 5;
    localparam int NumSlots      = 1 + Groups * SlotsPerGroup;
    localparam int WordW         = 6;

    typedef logic [WordW-1:0]    t_word;
    typedef logic [NumSlots-1:0] t_mask;

    localparam t_word TOK_ZERO      = t_word'(0);
    localparam t_word TOK_TEEN_BASE = t_word'(10);
    localparam t_word TOK_TENS_BASE = t_word'(18);
    localparam t_word TOK_HUNDRED   = t_word'(28);
    localparam t_word TOK_THOUSAND  = t_word'(29);
    localparam t_word TOK_NEGATIVE  = t_word'(32);

    typedef struct packed {
        logic            neg;
        logic [BcdW-1:0] bcd;
        logic [BinW-1:0] bin;
    } t_cell_data;

endpackage

/* sv/itew_cell.sv */
`timescale 1ns / 1ps
// One conversion cell: a single shift-and-add-three step of binary to BCD conversion,
// held in a pipeline register with valid/ready flow control. Depends on itew_pkg.
module itew_cell (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  itew_pkg::t_cell_data i_data,
    output logic                 o_valid,
    input  logic                 i_ready,
    output itew_pkg::t_cell_data o_data
);

    logic                 r_valid;
    itew_pkg::t_cell_data r_data;
    itew_pkg::t_cell_data n_data;

    assign o_ready = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_data  = r_data;

    always_comb begin
        logic [itew_pkg::BcdW-1:0]   adj;
        logic [itew_pkg::DigitW-1:0] dig;
        adj = '0;
        for (int d = 0; d < itew_pkg::BcdDigits; d++) begin
            dig = i_data.bcd[d*itew_pkg::DigitW +: itew_pkg::DigitW];
            adj[d*itew_pkg::DigitW +: itew_pkg::DigitW] =
                (dig >= itew_pkg::DigitW'(5)) ? dig + itew_pkg::DigitW'(3) : dig;
        end
        n_data.neg = i_data.neg;
        n_data.bcd = {adj[itew_pkg::BcdW-2:0], i_data.bin[itew_pkg::BinW-1]};
        n_data.bin = {i_data.bin[itew_pkg::BinW-2:0], 1'b0};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_data <= n_data;
        end
    end

endmodule

/* sv/itew_emit.sv */
`timescale 1ns / 1ps
// Token sequencer: turns a request's ten BCD digits into word tokens, handed out one
// per cycle while i_ready is high via an output register. Depends on itew_pkg.
module itew_emit (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  itew_pkg::t_cell_data i_data,
    output logic                 o_valid,
    input  logic                 i_ready,
    output itew_pkg::t_word      o_word,
    output logic                 o_last
);

    logic            r_busy;
    itew_pkg::t_mask r_mask;
    itew_pkg::t_word r_tok [itew_pkg::NumSlots];
    logic            r_out_valid;
    itew_pkg::t_word r_out_word;
    logic            r_out_last;

    itew_pkg::t_word new_tok [itew_pkg::NumSlots];
    itew_pkg::t_mask new_mask;
    itew_pkg::t_mask low;
    itew_pkg::t_word emit_word;
    logic            out_adv;
    logic            emit;
    logic            emit_last;
    logic            load;

    // Each group owns five slots in spoken order: hundreds digit, hundred,
    // teen or tens word, units word and scale word. Slot zero is the sign or zero.
    always_comb begin
        logic [itew_pkg::DigsW-1:0]  digs;
        logic [itew_pkg::DigitW-1:0] dh;
        logic [itew_pkg::DigitW-1:0] dt;
        logic [itew_pkg::DigitW-1:0] du;
        int                          base;
        digs     = itew_pkg::DigsW'(i_data.bcd);
        new_mask = '0;
        for (int s = 0; s < itew_pkg::NumSlots; s++) begin
            new_tok[s] = itew_pkg::TOK_ZERO;
        end
        new_tok[0]  = i_data.neg ? itew_pkg::TOK_NEGATIVE : itew_pkg::TOK_ZERO;
        new_mask[0] = i_data.neg || (i_data.bcd == '0);
        for (int g = 0; g < itew_pkg::Groups; g++) begin
            du   = digs[g*itew_pkg::GroupW +: itew_pkg::DigitW];
            dt   = digs[g*itew_pkg::GroupW + itew_pkg::DigitW +: itew_pkg::DigitW];
            dh   = digs[g*itew_pkg::GroupW + 2*itew_pkg::DigitW +: itew_pkg::DigitW];
            base = 1 + itew_pkg::SlotsPerGroup * (itew_pkg::Groups - 1 - g);
            new_tok[base]      = itew_pkg::WordW'(dh);
            new_mask[base]     = (dh != '0);
            new_tok[base+1]    = itew_pkg::TOK_HUNDRED;
            new_mask[base+1]   = (dh != '0);
            if (dt == itew_pkg::DigitW'(1)) begin
                new_tok[base+2]  = itew_pkg::TOK_TEEN_BASE + itew_pkg::WordW'(du);
                new_mask[base+2] = 1'b1;
            end else begin
                new_tok[base+2]  = itew_pkg::TOK_TENS_BASE + itew_pkg::WordW'(dt);
                new_mask[base+2] = (dt >= itew_pkg::DigitW'(2));
            end
            new_tok[base+3]  = itew_pkg::WordW'(du);
            new_mask[base+3] = (dt != itew_pkg::DigitW'(1)) && (du != '0);
            new_tok[base+4]  = itew_pkg::TOK_THOUSAND + itew_pkg::WordW'(g - 1);
            new_mask[base+4] = (g > 0) && ({dh, dt, du} != '0);
        end
    end

    // The lowest pending slot is the next token to go out.
    always_comb begin
        low       = r_mask & (~r_mask + itew_pkg::NumSlots'(1));
        emit_word = '0;
        for (int s = 0; s < itew_pkg::NumSlots; s++) begin
            emit_word = emit_word | (low[s] ? r_tok[s] : '0);
        end
    end

    assign out_adv   = !r_out_valid || i_ready;
    assign emit      = r_busy && out_adv;
    assign emit_last = ((r_mask & ~low) == '0);
    assign o_ready   = !r_busy || (emit && emit_last);
    assign load      = i_valid && o_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else if (load) begin
            r_busy <= 1'b1;
        end else if (emit && emit_last) begin
            r_busy <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_mask <= new_mask;
            r_tok  <= new_tok;
        end else if (emit) begin
            r_mask <= r_mask & ~low;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_adv) begin
            r_out_valid <= emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_out_word <= emit_word;
            r_out_last <= emit_last;
        end
    end

    assign o_valid = r_out_valid;
    assign o_word  = r_out_word;
    assign o_last  = r_out_last;

    a_busy_has_tokens: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> (r_mask != '0))
        else $error("sequencer busy with no tokens pending");

    a_load_only_on_final: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (load && r_busy) |-> (emit && emit_last))
        else $error("new request loaded over an unfinished one");

    a_idle_after_final: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (emit && emit_last && !load) |=> !r_busy)
        else $error("sequencer still busy after its final token");

    a_busy_midway: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (emit && !emit_last) |=> (r_busy && r_mask != '0))
        else $error("sequencer dropped a request before its final token");

endmodule

/* sv/integer_to_english_word_tokens_unit.sv */
`timescale 1ns / 1ps
// Top level of the integer to English word token unit: conversion cell chain and token
// sequencer. Depends on itew_pkg, itew_cell and itew_emit.
//
// Each request carries one signed 32-bit value and produces its English spelling as
// word tokens, one token per transfer with the final one flagged by o_last: Negative
// first for negative values, Zero alone for zero, otherwise hundreds, teen or tens and
// units, and a scale word for every non-zero group of three digits but the lowest. The
// value enters a chain of 32 identical cells, each performing one binary to BCD step,
// so a request passes through every cell register in turn before it is loaded into the
// token sequencer, whose output register then offers its first token. The sequencer
// sends one token per cycle while i_ready is high, so a request occupies it until all
// of its tokens, from one to seventeen, have gone; that token count sets the sustained
// rate, and further requests queue in the cell chain meanwhile.
module integer_to_english_word_tokens_unit (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_valid,
    output logic                    o_ready,
    input  logic signed [31:0]      i_value,
    output logic                    o_valid,
    input  logic                    i_ready,
    output logic [5:0]              o_word,
    output logic                    o_last
);

    logic                 c_valid [itew_pkg::NumCells+1];
    logic                 c_ready [itew_pkg::NumCells+1];
    itew_pkg::t_cell_data c_data  [itew_pkg::NumCells+1];
    logic [itew_pkg::BinW-1:0] raw;

    // The magnitude is taken as unsigned, so the most negative value keeps its true size.
    assign raw          = i_value;
    assign c_valid[0]   = i_valid;
    assign o_ready      = c_ready[0];
    assign c_data[0].neg = raw[itew_pkg::BinW-1];
    assign c_data[0].bcd = '0;
    assign c_data[0].bin = raw[itew_pkg::BinW-1] ? (~raw + itew_pkg::BinW'(1)) : raw;

    for (genvar i = 0; i < itew_pkg::NumCells; i++) begin : g_cell
        itew_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (c_valid[i]),
            .o_ready (c_ready[i]),
            .i_data  (c_data[i]),
            .o_valid (c_valid[i+1]),
            .i_ready (c_ready[i+1]),
            .o_data  (c_data[i+1])
        );
    end

    itew_emit u_emit (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (c_valid[itew_pkg::NumCells]),
        .o_ready (c_ready[itew_pkg::NumCells]),
        .i_data  (c_data[itew_pkg::NumCells]),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_word  (o_word),
        .o_last  (o_last)
    );

endmodule
